// ===== sv/pac_pkg.sv =====
// Shared types and constants for the particle attractor force block.
package pac_pkg;

    localparam int POS_W      = 16;
    localparam int ACC_W      = 34;
    localparam int DIFF_W     = 17;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 33;
    localparam int ROOT_W     = 17;
    localparam int PROD_W     = 32;
    localparam int NT_W       = 48;
    localparam int NUM_W      = 52;
    localparam int DEN_W      = 48;
    localparam int DD_W       = 35;
    localparam int SQRT_STEPS = 17;
    localparam int DIV_STEPS  = 52;
    localparam int CNT_W      = 6;
    localparam int ATTR_W     = 64;
    localparam int IDX_W      = 3;
    localparam int TS_W       = 16;
    localparam int DIST_BIAS  = 160;

    localparam logic [IDX_W-1:0] REG_REPELLER = 3'd4;
    localparam logic [IDX_W-1:0] REG_COUNT    = 3'd5;
    localparam logic [IDX_W-1:0] REG_TSTEP    = 3'd6;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [ACC_W-1:0] acc_x;
        logic signed [ACC_W-1:0] acc_y;
    } t_token;

    typedef enum logic [3:0] {
        C_IDLE, C_SQR, C_ROOT, C_CHK, C_MUL1, C_MUL2, C_SCALE, C_DIV, C_ACC, C_DONE
    } t_cell_state;

endpackage

// ===== sv/pac_cell.sv =====
// One attractor cell: adds the force of its attractor to the passing particle token.
module pac_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tok_valid,
    input  pac_pkg::t_token               i_tok,
    input  logic [pac_pkg::ATTR_W-1:0]    i_attr,
    input  logic                          i_rep,
    input  logic                          i_en,
    input  logic [pac_pkg::TS_W-1:0]      i_time_step,
    output logic                          o_tok_valid,
    output pac_pkg::t_token               o_tok
);

    pac_pkg::t_cell_state r_state, n_state;

    pac_pkg::t_token                     r_tok;
    logic signed [pac_pkg::DIFF_W-1:0]   r_dx, r_dy;
    logic        [pac_pkg::CNT_W-1:0]    r_cnt;
    logic        [33:0]                  r_sq_op;
    logic        [19:0]                  r_rem;
    logic        [pac_pkg::ROOT_W-1:0]   r_root;
    logic        [pac_pkg::MAG_W-1:0]    r_mdx, r_mdy, r_ms;
    logic                                r_negx, r_negy;
    logic        [pac_pkg::PROD_W-1:0]   r_px, r_py;
    logic        [pac_pkg::DD_W-1:0]     r_dd;
    logic        [pac_pkg::NT_W-1:0]     r_tx, r_ty;
    logic        [pac_pkg::NUM_W-1:0]    r_nx, r_ny;
    logic        [pac_pkg::DEN_W-1:0]    r_den;
    logic        [pac_pkg::DEN_W-1:0]    r_remx, r_remy;

    logic signed [pac_pkg::DIFF_W-1:0]   dx_in, dy_in;
    logic        [pac_pkg::MAG_W-1:0]    mdx, mdy, ms;
    logic signed [pac_pkg::POS_W-1:0]    strength;
    logic        [19:0]                  rem_sh, trial;
    logic        [pac_pkg::DEN_W:0]      remx_sh, remy_sh;
    logic                                qx, qy;
    logic signed [pac_pkg::ACC_W-1:0]    qmag_x, qmag_y;

    assign strength = i_attr[63:48];
    assign dx_in = {i_attr[15], i_attr[15:0]} - {i_tok.pos_x[15], i_tok.pos_x};
    assign dy_in = {i_attr[31], i_attr[31:16]} - {i_tok.pos_y[15], i_tok.pos_y};
    assign mdx = r_dx[16] ? pac_pkg::MAG_W'(-r_dx) : r_dx[15:0];
    assign mdy = r_dy[16] ? pac_pkg::MAG_W'(-r_dy) : r_dy[15:0];
    assign ms  = strength[15] ? pac_pkg::MAG_W'(-strength) : strength;

    assign rem_sh = {r_rem[17:0], r_sq_op[33:32]};
    assign trial  = {1'b0, r_root, 2'b01};

    assign remx_sh = {r_remx, r_nx[pac_pkg::NUM_W-1]};
    assign remy_sh = {r_remy, r_ny[pac_pkg::NUM_W-1]};
    assign qx = remx_sh >= {1'b0, r_den};
    assign qy = remy_sh >= {1'b0, r_den};
    assign qmag_x = {1'b0, r_nx[pac_pkg::ACC_W-2:0]};
    assign qmag_y = {1'b0, r_ny[pac_pkg::ACC_W-2:0]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pac_pkg::C_IDLE:  if (i_tok_valid) n_state = i_en ? pac_pkg::C_SQR : pac_pkg::C_DONE;
            pac_pkg::C_SQR:   n_state = pac_pkg::C_ROOT;
            pac_pkg::C_ROOT:  if (r_cnt == pac_pkg::CNT_W'(pac_pkg::SQRT_STEPS - 1))
                                  n_state = pac_pkg::C_CHK;
            pac_pkg::C_CHK:   n_state = (r_root == '0 || r_root >= {1'b0, i_attr[47:32]})
                                        ? pac_pkg::C_DONE : pac_pkg::C_MUL1;
            pac_pkg::C_MUL1:  n_state = pac_pkg::C_MUL2;
            pac_pkg::C_MUL2:  n_state = pac_pkg::C_SCALE;
            pac_pkg::C_SCALE: n_state = pac_pkg::C_DIV;
            pac_pkg::C_DIV:   if (r_cnt == pac_pkg::CNT_W'(pac_pkg::DIV_STEPS - 1))
                                  n_state = pac_pkg::C_ACC;
            pac_pkg::C_ACC:   n_state = pac_pkg::C_DONE;
            pac_pkg::C_DONE:  n_state = pac_pkg::C_IDLE;
            default:          n_state = pac_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        o_tok_valid = (r_state == pac_pkg::C_DONE);
        o_tok       = r_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pac_pkg::C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pac_pkg::C_IDLE: begin
                r_tok <= i_tok;
                r_dx  <= dx_in;
                r_dy  <= dy_in;
            end
            pac_pkg::C_SQR: begin
                r_sq_op <= {1'b0, pac_pkg::SQ_W'(mdx * mdx) + pac_pkg::SQ_W'(mdy * mdy)};
                r_rem   <= '0;
                r_root  <= '0;
                r_cnt   <= '0;
                r_mdx   <= mdx;
                r_mdy   <= mdy;
                r_ms    <= ms;
                r_negx  <= r_dx[16] ^ strength[15] ^ i_rep;
                r_negy  <= r_dy[16] ^ strength[15] ^ i_rep;
            end
            pac_pkg::C_ROOT: begin
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[15:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[15:0], 1'b0};
                end
                r_sq_op <= {r_sq_op[31:0], 2'b00};
                r_cnt   <= r_cnt + 1'b1;
            end
            pac_pkg::C_MUL1: begin
                r_px <= r_mdx * r_ms;
                r_py <= r_mdy * r_ms;
                r_dd <= r_root * ({1'b0, r_root} + 18'(pac_pkg::DIST_BIAS));
            end
            pac_pkg::C_MUL2: begin
                r_tx  <= r_px * i_time_step;
                r_ty  <= r_py * i_time_step;
                r_den <= {r_dd[33:0], 14'b0};
            end
            pac_pkg::C_SCALE: begin
                r_nx   <= ({4'b0, r_tx} << 3) + ({4'b0, r_tx} << 1);
                r_ny   <= ({4'b0, r_ty} << 3) + ({4'b0, r_ty} << 1);
                r_remx <= '0;
                r_remy <= '0;
                r_cnt  <= '0;
            end
            pac_pkg::C_DIV: begin
                r_remx <= qx ? pac_pkg::DEN_W'(remx_sh - {1'b0, r_den}) : remx_sh[47:0];
                r_remy <= qy ? pac_pkg::DEN_W'(remy_sh - {1'b0, r_den}) : remy_sh[47:0];
                r_nx   <= {r_nx[pac_pkg::NUM_W-2:0], qx};
                r_ny   <= {r_ny[pac_pkg::NUM_W-2:0], qy};
                r_cnt  <= r_cnt + 1'b1;
            end
            pac_pkg::C_ACC: begin
                r_tok.acc_x <= r_negx ? r_tok.acc_x - qmag_x : r_tok.acc_x + qmag_x;
                r_tok.acc_y <= r_negy ? r_tok.acc_y - qmag_y : r_tok.acc_y + qmag_y;
            end
            default: begin
            end
        endcase
    end

    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_valid |=> !o_tok_valid) else $error("cell token held past one cycle");
    a_idle_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_valid |-> r_state == pac_pkg::C_IDLE) else $error("token entered busy cell");
    a_root_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pac_pkg::C_ROOT |-> r_cnt < pac_pkg::CNT_W'(pac_pkg::SQRT_STEPS))
        else $error("root counter overran");

endmodule

// ===== sv/particle_attractor_force_top.sv =====
// Top level of the particle attractor force block: configuration, cell chain, saturation.
//
//  Channel   Handshake                 Beat contents
//  --------  ------------------------  ---------------------------------------
//  item in   start & !busy             i_pos_x, i_pos_y, i_vel_x, i_vel_y
//  result    o_valid (one cycle)       o_new_vel_x, o_new_vel_y, o_saturated
//  config    i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// A particle token walks the chain of attractor cells, one cell per attractor.
// An acting cell holds the token through load, a 17-step square root, the range
// check, three multiply stages, a 52-step restoring division for both axes side
// by side, the add and the hand-off. A cell whose attractor is out of range, or
// at zero distance, lets go after the check; a disabled cell goes straight to hand-off.
// The result beat comes from the saturating output register in the cycle after
// the token leaves the last cell; busy stays high from the accept until the token
// leaves, so the next item can be accepted in the cycle of the result beat.
// Synchronous active-low reset clears config and control, not the data registers.
// The receiver cannot stall: the result beat is shown for one cycle only.
module particle_attractor_force_top #(
    parameter int MAX_ATTRACTORS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [pac_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [pac_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [pac_pkg::POS_W-1:0]   i_vel_x,
    input  logic signed [pac_pkg::POS_W-1:0]   i_vel_y,
    output logic                               o_valid,
    output logic signed [pac_pkg::POS_W-1:0]   o_new_vel_x,
    output logic signed [pac_pkg::POS_W-1:0]   o_new_vel_y,
    output logic                               o_saturated,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pac_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [pac_pkg::ATTR_W-1:0]         i_cfg_data
);

    // Configuration registers.
    logic [pac_pkg::ATTR_W-1:0] r_attr [MAX_ATTRACTORS];
    logic [3:0]                 r_rep;
    logic [2:0]                 r_count;
    logic [pac_pkg::TS_W-1:0]   r_tstep;

    logic                       r_busy;
    logic                       r_out_valid;
    logic signed [pac_pkg::POS_W-1:0] r_vx, r_vy;
    logic                       r_sat;

    logic                       tok_valid [MAX_ATTRACTORS+1];
    pac_pkg::t_token            tok       [MAX_ATTRACTORS+1];
    logic                       accept;
    logic                       sat_xh, sat_xl, sat_yh, sat_yl;
    pac_pkg::t_token            last_tok;

    localparam logic signed [pac_pkg::ACC_W-1:0] SAT_HI = pac_pkg::ACC_W'(32767);
    localparam logic signed [pac_pkg::ACC_W-1:0] SAT_LO = -pac_pkg::ACC_W'(32768);

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !r_busy;
    assign busy        = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_ATTRACTORS; k++) r_attr[k] <= '0;
            r_rep   <= '0;
            r_count <= '0;
            r_tstep <= '0;
        end else if (i_cfg_valid) begin
            for (int k = 0; k < MAX_ATTRACTORS; k++) begin
                if (i_cfg_index == pac_pkg::IDX_W'(k)) r_attr[k] <= i_cfg_data;
            end
            if (i_cfg_index == pac_pkg::REG_REPELLER) r_rep   <= i_cfg_data[3:0];
            if (i_cfg_index == pac_pkg::REG_COUNT)    r_count <= i_cfg_data[2:0];
            if (i_cfg_index == pac_pkg::REG_TSTEP)    r_tstep <= i_cfg_data[15:0];
        end
    end

    // The token enters with the incoming velocity as the running sum.
    assign tok_valid[0]   = accept;
    assign tok[0].pos_x   = i_pos_x;
    assign tok[0].pos_y   = i_pos_y;
    assign tok[0].acc_x   = pac_pkg::ACC_W'(i_vel_x);
    assign tok[0].acc_y   = pac_pkg::ACC_W'(i_vel_y);

    // A cell is active when its index is below the count; a count above
    // the number of cells simply enables them all.
    for (genvar g = 0; g < MAX_ATTRACTORS; g++) begin : g_cell
        pac_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok_valid (tok_valid[g]),
            .i_tok       (tok[g]),
            .i_attr      (r_attr[g]),
            .i_rep       (r_rep[g]),
            .i_en        (r_count > 3'(g)),
            .i_time_step (r_tstep),
            .o_tok_valid (tok_valid[g+1]),
            .o_tok       (tok[g+1])
        );
    end

    assign last_tok = tok[MAX_ATTRACTORS];
    assign sat_xh = last_tok.acc_x > SAT_HI;
    assign sat_xl = last_tok.acc_x < SAT_LO;
    assign sat_yh = last_tok.acc_y > SAT_HI;
    assign sat_yl = last_tok.acc_y < SAT_LO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= tok_valid[MAX_ATTRACTORS];
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tok_valid[MAX_ATTRACTORS]) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_valid[MAX_ATTRACTORS]) begin
            r_vx  <= sat_xh ? 16'sh7fff : sat_xl ? 16'sh8000 : last_tok.acc_x[15:0];
            r_vy  <= sat_yh ? 16'sh7fff : sat_yl ? 16'sh8000 : last_tok.acc_y[15:0];
            r_sat <= sat_xh || sat_xl || sat_yh || sat_yl;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_new_vel_x = r_vx;
    assign o_new_vel_y = r_vy;
    assign o_saturated = r_sat;

    a_busy_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("busy not raised after accepted item");
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$past(r_busy) || !r_busy || $past(accept))
        else $error("result shown while item still in flight");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(tok_valid[MAX_ATTRACTORS]))
        else $error("result without token leaving the chain");

endmodule
